// ===== hw/rtl/cbfnc_pkg.sv =====
// Shared types and constants for the composite bitmap find-next-clear unit.
`timescale 1ns / 1ps
`default_nettype none

package cbfnc_pkg;

    // Width of the number field and of the operation code.
    localparam int NUM_W = 16;
    localparam int OP_W  = 2;

    // One past the largest value the number field can carry.
    localparam int NUM_LIMIT = 65536;

    // Shift of the fixed-point reciprocal used to divide a number by the word size.
    localparam int DIV_SH = 24;

    typedef enum logic [OP_W-1:0] {
        OP_MARK  = 2'd0,
        OP_TEST  = 2'd1,
        OP_FIND  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_ADDR,
        S_RMW,
        S_FCHK,
        S_FPOS,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/cbfnc_if.sv =====
// Valid/ready channel interfaces for the request and result words.
`timescale 1ns / 1ps
`default_nettype none

interface cbfnc_in_if;
    import cbfnc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [NUM_W-1:0] number;

    modport source (output valid, output op, output number, input ready);
    modport sink   (input valid, input op, input number, output ready);
endinterface

interface cbfnc_out_if;
    import cbfnc_pkg::*;

    logic             valid;
    logic             ready;
    logic             marked;
    logic [NUM_W-1:0] next_number;
    logic             none_found;
    logic             out_of_range;

    modport source (output valid, output marked, output next_number, output none_found,
                    output out_of_range, input ready);
    modport sink   (input valid, input marked, input next_number, input none_found,
                    input out_of_range, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cbfnc_mem.sv =====
// Bitmap word memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cbfnc_mem #(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 64
) (
    input  wire                        i_clk,
    input  wire                        i_we,
    input  wire  [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire  [WORD_BITS-1:0]       i_wdata,
    input  wire                        i_re,
    input  wire  [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WORD_BITS-1:0]       o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/cbfnc_zfind.sv =====
// Lowest-set-bit finder over one masked word of clear bits, with a registered index.
`timescale 1ns / 1ps
`default_nettype none

module cbfnc_zfind #(
    parameter int WORD_BITS = 64
) (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire  [WORD_BITS-1:0]         i_word,
    input  wire  [WORD_BITS-1:0]         i_mask,
    output logic                         o_hit,
    output logic [$clog2(WORD_BITS)-1:0] o_idx
);

    localparam int BIT_W = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] lowest;
    logic [BIT_W-1:0]     idx;
    logic [BIT_W-1:0]     r_idx;

    // Isolate the lowest candidate bit, then encode its position.
    always_comb begin
        cand   = ~i_word & i_mask;
        lowest = cand & (~cand + {{(WORD_BITS-1){1'b0}}, 1'b1});
        idx    = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (lowest[i]) begin
                idx = idx | BIT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx <= idx;
        end
    end

    assign o_hit = |cand;
    assign o_idx = r_idx;

endmodule

`default_nettype wire

// ===== hw/rtl/composite_bitmap_find_next_clear_unit.sv =====
// Top level of the composite bitmap store with mark, test, find-next-clear and clear.
`timescale 1ns / 1ps
`default_nettype none

// The unit keeps one bit per number, set when the number has been marked composite, in a
// single-port-write, registered-read memory of WORD_BITS-bit words. A request word carries an
// operation and a number: mark sets the number's bit, test returns it on marked, find returns
// the first unmarked number above the given one on next_number (or raises none_found when the
// search reaches the end of the store or 65535), and clear wipes the whole store. Mark, test
// and find raise out_of_range for numbers at or above NUMBER_COUNT and leave the store alone;
// every field an operation does not define reads as zero. Exactly one result word comes back
// for each request word, in order. Requests are handled one at a time by a sequencer around
// the memory: the number is split into word address and bit position by a reciprocal multiply,
// the word is read, and a mark writes it back in the next cycle, so no later read can reach
// that word before the write has landed. An out-of-range request reads no word. A find scans
// the words from the one that holds the bit after the given number, reading one word per cycle
// and checking it with a single lowest-clear-bit finder, and stops at a hit or at the last word;
// a find whose span is empty reads no word. A clear writes every memory word, one write per
// word, and after reset the same clearing pass runs before the first request is accepted. The
// result sits in an output register, so a new request is accepted while the previous result
// still waits to be taken.

module composite_bitmap_find_next_clear_unit #(
    parameter int NUMBER_COUNT = 65536,
    parameter int WORD_BITS    = 64
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    cbfnc_in_if.sink          i_in,
    cbfnc_out_if.source       o_out
);
    import cbfnc_pkg::*;

    // Only numbers the 16-bit field can reach ever touch the store.
    localparam int EFF       = (NUMBER_COUNT < NUM_LIMIT) ? NUMBER_COUNT : NUM_LIMIT;
    localparam int DEPTH     = (EFF + WORD_BITS - 1) / WORD_BITS;
    localparam int LAST_W    = DEPTH - 1;
    localparam int LAST_BITS = EFF - LAST_W * WORD_BITS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int W_W       = ADDR_W + 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int PROD_W    = DIV_SH + NUM_W + 1;
    localparam int RECIP     = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;

    localparam logic [WORD_BITS-1:0] ONES      = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] LAST_MASK = ONES >> (WORD_BITS - LAST_BITS);

    t_state r_state;
    t_state n_state;

    t_op              r_op;
    logic [NUM_W-1:0] r_num;
    logic [W_W-1:0]   r_q;
    logic             r_oor;
    logic [BIT_W-1:0] r_bit;
    logic [W_W-1:0]   r_w;
    logic [WORD_BITS-1:0] r_mask;
    logic             r_clr_op;

    logic             r_res_marked;
    logic [NUM_W-1:0] r_res_next;
    logic             r_res_none;
    logic             r_res_oor;

    logic             r_out_valid;
    logic             r_out_marked;
    logic [NUM_W-1:0] r_out_next;
    logic             r_out_none;
    logic             r_out_oor;

    // Memory port controls.
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    // Address split and find start.
    logic [PROD_W-1:0]    prod;
    logic [NUM_W-1:0]     q_times;
    logic [NUM_W-1:0]     rem_full;
    logic [BIT_W-1:0]     rem;
    logic [W_W-1:0]       start_w;
    logic [BIT_W-1:0]     start_b;
    logic                 start_past;
    logic                 last_word;
    logic [WORD_BITS-1:0] scan_mask;
    logic                 scan_hit;
    logic [BIT_W-1:0]     scan_idx;
    logic                 out_free;
    logic                 in_take;

    assign in_take  = (r_state == S_IDLE) && i_in.valid;
    assign out_free = !r_out_valid || o_out.ready;

    // Number divided by the word size: multiply by a rounded-up reciprocal, exact over
    // the whole 16-bit range. The quotient is registered before the remainder multiply.
    assign prod     = PROD_W'(r_num) * PROD_W'(RECIP);
    assign q_times  = NUM_W'(r_q) * NUM_W'(WORD_BITS);
    assign rem_full = r_num - q_times;
    assign rem      = rem_full[BIT_W-1:0];

    // A find starts at the bit after the given number, which may roll into the next word.
    always_comb begin
        if (rem == BIT_W'(WORD_BITS - 1)) begin
            start_w = r_q + W_W'(1);
            start_b = '0;
        end else begin
            start_w = r_q;
            start_b = rem + BIT_W'(1);
        end
        start_past = start_w > W_W'(LAST_W);
    end

    // Bits of the last word that lie beyond the searchable span never count as clear.
    assign last_word = r_w == W_W'(LAST_W);
    assign scan_mask = r_mask & (last_word ? LAST_MASK : ONES);

    cbfnc_mem #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    cbfnc_zfind #(
        .WORD_BITS (WORD_BITS)
    ) u_zfind (
        .i_clk  (i_clk),
        .i_en   (r_state == S_FCHK),
        .i_word (mem_rdata),
        .i_mask (scan_mask),
        .o_hit  (scan_hit),
        .o_idx  (scan_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state and memory accesses.
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_w[ADDR_W-1:0];
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_q[ADDR_W-1:0];
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (last_word) begin
                    n_state = r_clr_op ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = (t_op'(i_in.op) == OP_CLEAR) ? S_CLEAR : S_DIV;
                end
            end
            S_DIV: begin
                n_state = S_ADDR;
            end
            S_ADDR: begin
                if (r_oor) begin
                    n_state = S_DONE;
                end else if (r_op == OP_FIND) begin
                    mem_raddr = start_w[ADDR_W-1:0];
                    if (start_past) begin
                        n_state = S_DONE;
                    end else begin
                        mem_re  = 1'b1;
                        n_state = S_FCHK;
                    end
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_RMW;
                end
            end
            S_RMW: begin
                if (r_op == OP_MARK) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_q[ADDR_W-1:0];
                    mem_wdata = mem_rdata | ({{(WORD_BITS-1){1'b0}}, 1'b1} << r_bit);
                end
                n_state = S_DONE;
            end
            S_FCHK: begin
                // The next word is fetched while this one is checked.
                mem_raddr = r_w[ADDR_W-1:0] + ADDR_W'(1);
                if (scan_hit) begin
                    n_state = S_FPOS;
                end else if (last_word) begin
                    n_state = S_DONE;
                end else begin
                    mem_re = 1'b1;
                end
            end
            S_FPOS: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers of the sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w      <= '0;
            r_clr_op <= 1'b0;
        end else begin
            if (in_take) begin
                r_w      <= '0;
                r_clr_op <= 1'b1;
            end else if (r_state == S_CLEAR) begin
                r_w <= r_w + W_W'(1);
            end else if (r_state == S_ADDR) begin
                r_w <= start_w;
            end else if (r_state == S_FCHK && !scan_hit && !last_word) begin
                r_w <= r_w + W_W'(1);
            end
        end
    end

    // Request payload and the result being built.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op         <= t_op'(i_in.op);
            r_num        <= i_in.number;
            r_res_marked <= 1'b0;
            r_res_next   <= '0;
            r_res_none   <= 1'b0;
            r_res_oor    <= 1'b0;
        end
        unique case (r_state)
            S_DIV: begin
                r_q       <= prod[DIV_SH +: W_W];
                r_oor     <= 32'(r_num) >= 32'(NUMBER_COUNT);
                r_res_oor <= 32'(r_num) >= 32'(NUMBER_COUNT);
            end
            S_ADDR: begin
                r_bit  <= rem;
                r_mask <= ONES << start_b;
                if (!r_oor && r_op == OP_FIND && start_past) begin
                    r_res_none <= 1'b1;
                end
            end
            S_RMW: begin
                if (r_op == OP_TEST) begin
                    r_res_marked <= mem_rdata[r_bit];
                end
            end
            S_FCHK: begin
                r_mask <= ONES;
                if (!scan_hit && last_word) begin
                    r_res_none <= 1'b1;
                end
            end
            S_FPOS: begin
                r_res_next <= NUM_W'(r_w) * NUM_W'(WORD_BITS) + NUM_W'(scan_idx);
            end
            S_CLEAR, S_IDLE, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Output register: loads a finished result once the previous one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_marked <= r_res_marked;
            r_out_next   <= r_res_next;
            r_out_none   <= r_res_none;
            r_out_oor    <= r_res_oor;
        end
    end

    assign i_in.ready         = r_state == S_IDLE;
    assign o_out.valid        = r_out_valid;
    assign o_out.marked       = r_out_marked;
    assign o_out.next_number  = r_out_next;
    assign o_out.none_found   = r_out_none;
    assign o_out.out_of_range = r_out_oor;

endmodule

`default_nettype wire

// ===== hw/rtl/cbfnc_chk.sv =====
// Port-level checker for the composite bitmap unit and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cbfnc_chk (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_in_valid,
    input wire                         i_in_ready,
    input wire                         i_out_valid,
    input wire                         i_out_ready,
    input wire                         i_marked,
    input wire [cbfnc_pkg::NUM_W-1:0]  i_next_number,
    input wire                         i_none_found,
    input wire                         i_out_of_range
);
    import cbfnc_pkg::*;

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pending;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Request words accepted whose result words are not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_acc && !out_acc) begin
            r_pending <= r_pending + 2'd1;
        end else if (out_acc && !in_acc) begin
            r_pending <= r_pending - 2'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_next_number)
            && $stable(i_marked) && $stable(i_none_found) && $stable(i_out_of_range))
        else $error("result word changed while stalled");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 2'd0)
        else $error("result word without an outstanding request");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("request taken while another is in progress");

    a_oor_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_of_range |-> !i_marked && !i_none_found
            && i_next_number == '0)
        else $error("out-of-range result carries other fields");

    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_none_found |-> !i_marked && i_next_number == '0)
        else $error("failed search carries a number");

endmodule

bind composite_bitmap_find_next_clear_unit cbfnc_chk u_cbfnc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_marked       (o_out.marked),
    .i_next_number  (o_out.next_number),
    .i_none_found   (o_out.none_found),
    .i_out_of_range (o_out.out_of_range)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the composite bitmap find-next-clear unit.
`timescale 1ns / 1ps

package cbfnc_tb_pkg;
    import cbfnc_pkg::*;

    typedef struct packed {
        logic             marked;
        logic [NUM_W-1:0] next_number;
        logic             none_found;
        logic             out_of_range;
    } t_result;

    // Shadow copy of the composite bitmap and the queue of results still owed by the unit.
    class bitmap_scoreboard;
        bit          composite_bits [NUM_LIMIT];
        t_result     owed_results [$];
        int unsigned number_count;
        int unsigned mismatches;
        int unsigned results_checked;
        int unsigned op_counts [4];
        int unsigned none_found_count;
        int unsigned marked_hits;

        function new(int unsigned count);
            number_count = count;
            foreach (composite_bits[i]) composite_bits[i] = 1'b0;
        endfunction

        // Applies an accepted request to the shadow store and queues the result it must produce.
        function void note_request(t_op op, logic [NUM_W-1:0] num);
            t_result     want;
            int unsigned span_end;
            int unsigned k;
            want = '0;
            op_counts[op]++;
            span_end = (number_count < NUM_LIMIT) ? number_count : NUM_LIMIT;
            if (op == OP_CLEAR) begin
                foreach (composite_bits[i]) composite_bits[i] = 1'b0;
            end else if (int'(num) >= number_count) begin
                want.out_of_range = 1'b1;
            end else if (op == OP_MARK) begin
                composite_bits[num] = 1'b1;
            end else if (op == OP_TEST) begin
                want.marked = composite_bits[num];
                if (want.marked) marked_hits++;
            end else begin
                want.none_found = 1'b1;
                for (k = int'(num) + 1; k < span_end; k++) begin
                    if (!composite_bits[k]) begin
                        want.next_number = NUM_W'(k);
                        want.none_found  = 1'b0;
                        break;
                    end
                end
                if (want.none_found) none_found_count++;
            end
            owed_results.push_back(want);
        endfunction

        function void check_result(t_result got);
            t_result want;
            results_checked++;
            if (owed_results.size() == 0) begin
                $error("result word with nothing outstanding: marked=%0d next_number=%0d none_found=%0d out_of_range=%0d",
                       got.marked, got.next_number, got.none_found, got.out_of_range);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (got.marked !== want.marked) begin
                $error("marked: expected %0d, got %0d", want.marked, got.marked);
                mismatches++;
            end
            if (got.next_number !== want.next_number) begin
                $error("next_number: expected %0d, got %0d", want.next_number, got.next_number);
                mismatches++;
            end
            if (got.none_found !== want.none_found) begin
                $error("none_found: expected %0d, got %0d", want.none_found, got.none_found);
                mismatches++;
            end
            if (got.out_of_range !== want.out_of_range) begin
                $error("out_of_range: expected %0d, got %0d", want.out_of_range, got.out_of_range);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return owed_results.size();
        endfunction
    endclass

endpackage

module tb_top;
    import cbfnc_pkg::*;
    import cbfnc_tb_pkg::*;

    localparam int NUMBER_COUNT = 65536;
    localparam int WORD_BITS    = 64;
    localparam int RANDOM_WORDS = 1150;
    // The reset clearing pass, an occasional clear and long stalls on both sides
    // stay well below this; it only catches a hang.
    localparam int CYCLE_LIMIT  = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cbfnc_in_if  req_if ();
    cbfnc_out_if res_if ();

    composite_bitmap_find_next_clear_unit #(
        .NUMBER_COUNT (NUMBER_COUNT),
        .WORD_BITS    (WORD_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    bitmap_scoreboard sb = new(NUMBER_COUNT);

    // While calm is set neither side inserts gaps, so back-to-back traffic is seen too.
    bit          calm = 1'b0;
    int unsigned words_sent = 0;
    int unsigned cycle_count = 0;

    always #5 i_clk = ~i_clk;

    // Every input of the unit starts at a known value; the request side is idle until reset ends.
    initial begin
        req_if.valid  = 1'b0;
        req_if.op     = OP_MARK;
        req_if.number = '0;
        res_if.ready  = 1'b0;
    end

    // The run is bounded by a plain cycle count so that a hung handshake cannot stall forever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, sb.outstanding());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Each result word is checked at the rising edge where it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_result('{marked:       res_if.marked,
                              next_number:  res_if.next_number,
                              none_found:   res_if.none_found,
                              out_of_range: res_if.out_of_range});
        end
    end

    // The result side alternates ready stretches with stalls, and roughly one stall in sixteen
    // is long enough to back the unit up behind its output register.
    initial begin
        int unsigned hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (calm || $urandom_range(0, 3) != 0) begin
                res_if.ready = 1'b1;
                hold = $urandom_range(0, 15);
            end else begin
                res_if.ready = 1'b0;
                hold = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
            end
        end
    end

    // Picks the idle gap before the next request word; most often there is none.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Presents one request word after a random gap and holds it until the unit takes it.
    // Valid is only changed on falling edges, so it is never lowered and raised in one step.
    task automatic send_request(input t_op op, input logic [NUM_W-1:0] num);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid  = 1'b1;
        req_if.op     = op;
        req_if.number = num;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(op, num);
        words_sent++;
    endtask

    // Stops sending until every owed result has been taken.
    task automatic drain_results();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Mark, test or find, weighted toward marking so that searches have runs to skip over.
    function automatic t_op pick_access_op();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return OP_MARK;
        if (roll < 70) return OP_TEST;
        return OP_FIND;
    endfunction

    // Random requests grouped into episodes: clustered accesses that revisit the same words,
    // filled runs followed by searches that must scan across them, uniform noise, traffic at
    // the top of the number range, and an occasional clear.
    task automatic run_random_traffic();
        int unsigned      episode;
        int unsigned      len;
        int unsigned      i;
        logic [NUM_W-1:0] base;
        bit               paused;
        paused = 1'b0;
        while (words_sent < RANDOM_WORDS + 25) begin
            calm    = ($urandom_range(0, 4) == 0);
            episode = $urandom_range(0, 99);
            if (!paused && words_sent > RANDOM_WORDS / 2) begin
                drain_results();
                paused = 1'b1;
            end
            if (episode < 6) begin
                send_request(OP_CLEAR, NUM_W'($urandom_range(0, 65535)));
            end else if (episode < 55) begin
                // A small window, often aligned to a word, so marks and tests land together.
                base = NUM_W'($urandom_range(0, 65535));
                if ($urandom_range(0, 1) == 0) base = base & ~NUM_W'(WORD_BITS - 1);
                len = $urandom_range(5, 30);
                for (i = 0; i < len; i++) begin
                    send_request(pick_access_op(), base + NUM_W'($urandom_range(0, 130)));
                end
            end else if (episode < 78) begin
                // Fill a contiguous run, search below it, probe inside it and just past it.
                base = NUM_W'($urandom_range(0, 65535));
                len  = $urandom_range(1, 140);
                for (i = 0; i < len; i++) begin
                    send_request(OP_MARK, base + NUM_W'(i));
                end
                send_request(OP_FIND, base - 1'b1);
                send_request(OP_FIND, base + NUM_W'($urandom_range(0, len - 1)));
                send_request(OP_TEST, base + NUM_W'($urandom_range(0, len)));
            end else if (episode < 93) begin
                for (i = 0; i < 10; i++) begin
                    send_request(pick_access_op(), NUM_W'($urandom_range(0, 65535)));
                end
            end else begin
                // Near the top the search runs out of numbers, which raises none_found.
                len = $urandom_range(5, 25);
                for (i = 0; i < len; i++) begin
                    send_request(pick_access_op(), NUM_W'(65535 - $urandom_range(0, 70)));
                end
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed requests: empty store, neighbors across a word boundary, the last number,
        // a find whose span is empty, a find that runs out of numbers, and a clear that
        // carries a nonzero number.
        send_request(OP_CLEAR, '0);
        send_request(OP_TEST,  16'd0);
        send_request(OP_FIND,  16'd0);
        send_request(OP_MARK,  16'd0);
        send_request(OP_TEST,  16'd0);
        send_request(OP_MARK,  16'd1);
        send_request(OP_MARK,  16'd2);
        send_request(OP_FIND,  16'd0);
        send_request(OP_MARK,  16'd63);
        send_request(OP_MARK,  16'd64);
        send_request(OP_FIND,  16'd62);
        send_request(OP_TEST,  16'd64);
        send_request(OP_MARK,  16'hFFFF);
        send_request(OP_TEST,  16'hFFFF);
        send_request(OP_FIND,  16'hFFFE);
        send_request(OP_FIND,  16'hFFFF);
        send_request(OP_MARK,  16'hFFFE);
        send_request(OP_FIND,  16'hFFFD);
        send_request(OP_FIND,  16'h7FFF);
        send_request(OP_TEST,  16'h3039);
        send_request(OP_CLEAR, 16'hFFFF);
        send_request(OP_TEST,  16'hFFFF);
        send_request(OP_FIND,  16'hFFFE);

        run_random_traffic();

        drain_results();
        repeat (20) @(posedge i_clk);

        $display("%0d request words: %0d mark, %0d test, %0d find, %0d clear; %0d results checked",
                 words_sent, sb.op_counts[OP_MARK], sb.op_counts[OP_TEST],
                 sb.op_counts[OP_FIND], sb.op_counts[OP_CLEAR], sb.results_checked);
        $display("tests that hit a marked number: %0d, searches that found nothing: %0d",
                 sb.marked_hits, sb.none_found_count);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
